@@ rtl/core/slir_pkg.sv @@
// Shared types and constants for the sorted list insert/remove block.
package slir_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 6;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef enum logic [1:0] {
		PH_CMP = 2'b01,
		PH_UPD = 2'b10
	} phase_t;

endpackage

@@ rtl/core/slir_if.sv @@
// Request and response channel interfaces with valid/ready handshake.
interface slir_req_if import slir_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface slir_rsp_if import slir_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic [COUNT_W-1:0]        count;
	logic signed [VALUE_W-1:0] smallest;

	modport source (output valid, output ok, output count, output smallest, input ready);
	modport sink (input valid, input ok, input count, input smallest, output ready);
endinterface

@@ rtl/core/sorted_list_insert_remove.sv @@
// Sorted list top level: keeps up to CAPACITY signed 32-bit values in ascending order;
// each request word inserts a value (duplicates kept) or removes one occurrence of it,
// and returns one response word with success, the count held and the smallest value
// (0 when empty). Request words land in a two-entry queue; the back end finishes one
// item before taking the next: a compare phase checks the value against every cell of
// the sorted row in parallel, then an update phase shifts the row and writes the
// response register, waiting while that register holds an untaken word. The per-cell
// compare against all CAPACITY cells and the match reduction set the clock period.
module sorted_list_insert_remove import slir_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	slir_req_if.sink   req,
	slir_rsp_if.source rsp
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	slir_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	slir_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

@@ rtl/core/slir_front.sv @@
// Front end: accepts request words, classifies them and queues them for the back end.
module slir_front import slir_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	slir_req_if.sink   req,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	item_t       item_in;

	assign req.ready = (fill_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (fill_q != 2'd0);
	assign q_item    = mem_q[rd_ptr_q];

	always_comb begin
		item_in.value = req.value;
		case (req.kind)
			1'b0:    item_in.op = OP_INSERT;
			default: item_in.op = OP_REMOVE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("queue fill out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> fill_q != 2'd0)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd2) |=> fill_q != 2'd0 || $past(q_pop))
		else $error("queue fill jumped");

endmodule

@@ rtl/core/slir_back.sv @@
// Back end: row of sorted cells with compare and shift phases and a result register.
module slir_back import slir_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_pop,
	slir_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [VALUE_W-1:0] cell_q [CAPACITY];
	logic signed [VALUE_W-1:0] cell_d [CAPACITY];
	logic [CAPACITY-1:0]       lt_s1;
	logic [CAPACITY-1:0]       eq_s1;
	logic [CAPACITY-1:0]       hit;
	logic [CAPACITY-1:0]       lt_now;
	logic [CAPACITY-1:0]       eq_now;
	item_t                     item_s1;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             cnt_d;
	phase_t                    phase_q;
	logic                      full;
	logic                      found;
	logic                      ins_go;
	logic                      rem_go;
	logic                      commit;
	logic                      res_valid_q;
	logic                      ok_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [VALUE_W-1:0] smallest_q;

	assign full   = (cnt_q == CW'(CAPACITY));
	assign found  = |hit;
	assign ins_go = (item_s1.op == OP_INSERT) && !full;
	assign rem_go = (item_s1.op == OP_REMOVE) && found;
	assign q_pop  = (phase_q == PH_CMP) && q_valid;
	assign commit = (phase_q == PH_UPD) && (!res_valid_q || rsp.ready);

	always_comb begin
		case ({ins_go, rem_go})
			2'b10:   cnt_d = cnt_q + CW'(1);
			2'b01:   cnt_d = cnt_q - CW'(1);
			default: cnt_d = cnt_q;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                      prev_lt;
		logic signed [VALUE_W-1:0] prev_val;
		logic signed [VALUE_W-1:0] next_val;
		logic                      held;

		assign held      = (cnt_q > CW'(i));
		assign lt_now[i] = held && (cell_q[i] < q_item.value);
		assign eq_now[i] = held && (cell_q[i] == q_item.value);

		if (i == 0) begin : g_first
			assign prev_lt  = 1'b1;
			assign prev_val = cell_q[i];
		end else begin : g_rest
			assign prev_lt  = lt_s1[i-1];
			assign prev_val = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_val = cell_q[i];
		end else begin : g_mid
			assign next_val = cell_q[i+1];
		end

		assign hit[i] = eq_s1[i] && prev_lt;

		always_comb begin
			cell_d[i] = cell_q[i];
			if (ins_go && !lt_s1[i]) begin
				cell_d[i] = prev_lt ? item_s1.value : prev_val;
			end else if (rem_go && !lt_s1[i]) begin
				cell_d[i] = next_val;
			end
		end

		always_ff @(posedge clk) begin
			if (commit) begin
				cell_q[i] <= cell_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			lt_s1   <= lt_now;
			eq_s1   <= eq_now;
			item_s1 <= q_item;
		end
		if (commit) begin
			ok_q       <= ins_go || rem_go;
			count_q    <= COUNT_W'(cnt_d);
			smallest_q <= (cnt_d == CW'(0)) ? '0 : cell_d[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CMP;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (phase_q)
				PH_CMP: begin
					if (q_valid) begin
						phase_q <= PH_UPD;
					end
				end
				PH_UPD: begin
					if (commit) begin
						phase_q <= PH_CMP;
					end
				end
				default: phase_q <= PH_CMP;
			endcase
			if (commit) begin
				cnt_q <= cnt_d;
			end
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid    = res_valid_q;
	assign rsp.ok       = ok_q;
	assign rsp.count    = count_q;
	assign rsp.smallest = smallest_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("count above capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_UPD) |-> $onehot0(hit))
		else $error("remove matched more than one boundary cell");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> res_valid_q)
		else $error("result word lost after commit");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && ins_go) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not advance count");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !rsp.ready) |=> res_valid_q && $stable(smallest_q))
		else $error("stalled result word changed");

endmodule

@@ tb/sv/tb_sorted_list_insert_remove.sv @@
// Testbench for the sorted list insert/remove block: random traffic checked against a list model.
module tb_sorted_list_insert_remove;
	import slir_pkg::*;

	localparam int CAPACITY = 32;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam int N_ITEMS = 1950;

	typedef struct {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
		bit                        wait_idle;
	} list_op_t;

	typedef struct {
		logic                      ok;
		logic [COUNT_W-1:0]        count;
		logic signed [VALUE_W-1:0] smallest;
	} list_status_t;

	logic clk = 1'b0;
	logic arst_n;

	slir_req_if req_if ();
	slir_rsp_if rsp_if ();

	sorted_list_insert_remove #(.CAPACITY(CAPACITY)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always #1 clk = ~clk;

	list_op_t                  queued_ops[$];
	list_status_t              due_status[$];
	logic signed [VALUE_W-1:0] held_vals[$];
	logic signed [VALUE_W-1:0] gen_pool[$];
	logic signed [VALUE_W-1:0] hot_vals[8];
	int                        mismatches = 0;
	int                        n_ops = 0;

	// list model: ascending, new value goes before any equal ones
	function automatic list_status_t update_held_list(op_t op, logic signed [VALUE_W-1:0] v);
		list_status_t st;
		int pos;
		pos = 0;
		st.ok = 1'b0;
		while (pos < held_vals.size() && held_vals[pos] < v)
			pos++;
		if (op == OP_INSERT) begin
			if (held_vals.size() < CAPACITY) begin
				held_vals.insert(pos, v);
				st.ok = 1'b1;
			end
		end else if (pos < held_vals.size() && held_vals[pos] == v) begin
			held_vals.delete(pos);
			st.ok = 1'b1;
		end
		st.count = COUNT_W'(held_vals.size());
		st.smallest = (held_vals.size() > 0) ? held_vals[0] : '0;
		return st;
	endfunction

	task automatic add_op(op_t op, logic signed [VALUE_W-1:0] v, bit wait_idle);
		list_op_t item;
		int i;
		item.op = op;
		item.value = v;
		item.wait_idle = wait_idle;
		queued_ops.push_back(item);
		n_ops++;
		if (op == OP_INSERT) begin
			if (gen_pool.size() < CAPACITY)
				gen_pool.push_back(v);
		end else begin
			for (i = 0; i < gen_pool.size(); i++)
				if (gen_pool[i] == v) begin
					gen_pool.delete(i);
					break;
				end
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
			3, 4, 5: return hot_vals[$urandom_range(0, 7)];
			6: return $signed(VALUE_W'($urandom_range(0, 20))) - 32'sd10;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_held();
		if (gen_pool.size() > 0 && $urandom_range(0, 4) != 0)
			return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
		return pick_value();
	endfunction

	// driver
	int burst_left;
	int gap_left;
	int in_flight;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
			in_flight = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				due_status.push_back(update_held_list(op_t'(req_if.kind), req_if.value));
				in_flight++;
			end
			if (rsp_if.valid && rsp_if.ready)
				in_flight--;
			if (!req_if.valid || req_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (queued_ops.size() == 0 || (queued_ops[0].wait_idle && in_flight != 0)) begin
					req_if.valid <= 1'b0;
				end else begin
					req_if.valid <= 1'b1;
					req_if.kind <= queued_ops[0].op;
					req_if.value <= queued_ops[0].value;
					queued_ops.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// monitor and response stall pattern
	int results_seen;
	int hold_left;
	int next_hold_at;
	int stall_mode;
	int mode_left;
	int pat_cnt;
	always @(posedge clk or negedge arst_n) begin
		list_status_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			results_seen = 0;
			hold_left = 0;
			next_hold_at = 300;
			stall_mode = 0;
			mode_left = 0;
			pat_cnt = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (due_status.size() == 0) begin
					$display("%0t: unexpected word ok=%0b count=%0d smallest=%0d", $time,
						rsp_if.ok, rsp_if.count, rsp_if.smallest);
					mismatches++;
				end else begin
					want = due_status.pop_front();
					if (rsp_if.ok !== want.ok) begin
						$display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_if.ok);
						mismatches++;
					end
					if (rsp_if.count !== want.count) begin
						$display("%0t: count expected %0d actual %0d", $time,
							want.count, rsp_if.count);
						mismatches++;
					end
					if (rsp_if.smallest !== want.smallest) begin
						$display("%0t: smallest expected %0d actual %0d", $time,
							want.smallest, rsp_if.smallest);
						mismatches++;
					end
				end
			end
			pat_cnt++;
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (results_seen >= next_hold_at) begin
				hold_left = 120;
				next_hold_at += 800;
				rsp_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_if.ready <= (pat_cnt % 3 != 0);
					default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin
		int seg;
		int len;
		int mode;
		int ins_pct;
		int i;
		bit is_ins;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.kind = 1'b0;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		for (i = 0; i < 8; i++)
			hot_vals[i] = $signed($urandom);

		add_op(OP_REMOVE, 32'sd0, 1'b0);
		add_op(OP_INSERT, 32'sd7, 1'b0);
		add_op(OP_REMOVE, 32'sd5, 1'b0);
		add_op(OP_INSERT, VAL_MAX, 1'b0);
		add_op(OP_INSERT, VAL_MIN, 1'b0);
		add_op(OP_INSERT, 32'sd0, 1'b0);
		add_op(OP_INSERT, 32'sd0, 1'b0);
		add_op(OP_INSERT, -32'sd1, 1'b0);
		add_op(OP_INSERT, VAL_MIN, 1'b0);
		add_op(OP_REMOVE, VAL_MIN, 1'b0);
		add_op(OP_REMOVE, VAL_MIN, 1'b0);
		add_op(OP_REMOVE, VAL_MIN, 1'b0);
		add_op(OP_REMOVE, 32'sd0, 1'b0);
		add_op(OP_REMOVE, 32'sd0, 1'b0);
		add_op(OP_REMOVE, 32'sd0, 1'b0);
		add_op(OP_REMOVE, VAL_MAX, 1'b0);
		add_op(OP_INSERT, 32'sh5555_5555, 1'b0);
		add_op(OP_INSERT, 32'shaaaa_aaaa, 1'b0);
		add_op(OP_REMOVE, 32'sd7, 1'b0);
		add_op(OP_REMOVE, -32'sd1, 1'b0);
		add_op(OP_REMOVE, 32'sh5555_5555, 1'b0);
		add_op(OP_REMOVE, 32'shaaaa_aaaa, 1'b0);
		add_op(OP_REMOVE, 32'sd7, 1'b0);

		// fill-heavy, drain-heavy, balanced and noise segments
		seg = 0;
		while (n_ops < N_ITEMS) begin
			mode = $urandom_range(0, 7);
			len = $urandom_range(8, 60);
			case (mode)
				0, 1, 2: ins_pct = 85;
				3, 4: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			for (i = 0; i < len && n_ops < N_ITEMS; i++) begin
				is_ins = ($urandom_range(0, 99) < ins_pct);
				if (mode == 7)
					add_op(op_t'($urandom_range(0, 1)), $signed($urandom), 1'b0);
				else if (is_ins)
					add_op(OP_INSERT, pick_value(), (i == 0 && seg % 7 == 0));
				else
					add_op(OP_REMOVE, pick_held(), (i == 0 && seg % 7 == 0));
			end
			seg++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_ops.size() != 0 || req_if.valid || due_status.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/slir_pkg.sv
rtl/core/slir_if.sv
rtl/core/slir_front.sv
rtl/core/slir_back.sv
rtl/core/sorted_list_insert_remove.sv
tb/sv/tb_sorted_list_insert_remove.sv
